FILE: hdl/arpc_pkg.sv
// Shared types and constants for the ARP responder with address cache.
// No dependencies; imported by every module of the block but arpc_fifo.
`default_nettype none
package arpc_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int QUEUE_DEPTH       = 2;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;

	// register byte addresses, decoded on paddr[3]
	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP  = 1'b1;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [7:0]  HW_LEN_ETH   = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IP = 8'd4;
	localparam logic [15:0] ARP_REQUEST  = 16'h0001;
	localparam logic [47:0] MAC_BCAST    = 48'hffff_ffff_ffff;

	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_REPLY    = 2'd1;
	localparam logic [1:0] ACT_BCAST    = 2'd2;
	localparam logic [1:0] ACT_ANSWERED = 2'd3;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_BAD_LEN = 2'd1;
	localparam logic [1:0] STS_NOT_US  = 2'd2;
	localparam logic [1:0] STS_FULL    = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] arp_oper;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [31:0] query_ip;
	} item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  status;
		logic        learned;
		logic [47:0] pkt_dest_mac;
		logic [31:0] pkt_dest_ip;
		logic [47:0] found_mac;
	} result_t;

	// classified request handed from front to back
	typedef struct packed {
		logic        drop;
		logic        is_query;
		logic        own_query;
		logic        learn_cand;
		logic        search;
		logic        tgt_us;
		logic        oper_req;
		logic [31:0] key_ip;
		logic [47:0] mac;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CMP,
		BK_DONE
	} back_state_t;

endpackage
`default_nettype wire

FILE: hdl/arpc_fifo.sv
// Small synchronous queue of any packed type.
// Depends on nothing but its parameters.
`default_nettype none
module arpc_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     din,
	output logic      full,
	input  wire logic pop,
	output T          dout,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule
`default_nettype wire

FILE: hdl/arpc_front.sv
// Front end: takes requests, classifies them and hands them to the command queue.
// Depends on arpc_pkg.
`default_nettype none
module arpc_front
	import arpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire item_t       item,
	input  wire logic [31:0] own_ip,
	output logic             cmd_push,
	output cmd_t             cmd,
	input  wire logic        cmd_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cls;
	logic accept;

	always_comb begin
		cls            = '0;
		cls.is_query   = (item.operation == OP_QUERY);
		cls.drop       = !cls.is_query &&
		                 ((item.hw_len != HW_LEN_ETH) || (item.proto_len != PROTO_LEN_IP));
		cls.own_query  = cls.is_query && (item.query_ip == own_ip);
		cls.learn_cand = !cls.is_query && !cls.drop &&
		                 (item.sender_ip != '0) && (item.sender_ip != own_ip);
		cls.search     = cls.is_query ? !cls.own_query : cls.learn_cand;
		cls.tgt_us     = (item.target_ip == own_ip);
		cls.oper_req   = (item.arp_oper == ARP_REQUEST);
		cls.key_ip     = cls.is_query ? item.query_ip : item.sender_ip;
		cls.mac        = item.sender_mac;
	end

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (cmd_push)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_s1 <= cls;
	end

endmodule
`default_nettype wire

FILE: hdl/arpc_back.sv
// Back end: searches and updates the address table, builds one result per request.
// Depends on arpc_pkg.
`default_nettype none
module arpc_back
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_empty,
	input  wire cmd_t        cmd,
	output logic             cmd_pop,
	input  wire logic [47:0] own_mac,
	input  wire logic        res_full,
	output logic             res_push,
	output result_t          res
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic [31:0] mem_ip  [TABLE_ENTRIES];
	logic [47:0] mem_mac [TABLE_ENTRIES];

	back_state_t      st_q, st_nxt;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] count_q;
	logic             hit_q;
	logic [31:0]      rd_ip_q;
	logic [47:0]      rd_mac_q;

	logic tbl_full, match, last, rd_en, learn, miss_new;

	assign tbl_full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign match    = (rd_ip_q == cmd_q.key_ip);
	assign last     = (CNT_W'(addr_q) == count_q - 1'b1);
	assign miss_new = !cmd_q.drop && !cmd_q.is_query && cmd_q.learn_cand && !hit_q;

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			BK_IDLE:
				if (!cmd_empty && !res_full)
					st_nxt = (cmd.search && count_q != '0) ? BK_READ : BK_DONE;
			BK_READ:
				st_nxt = BK_CMP;
			BK_CMP:
				st_nxt = (match || last) ? BK_DONE : BK_READ;
			BK_DONE:
				st_nxt = BK_IDLE;
			default:
				st_nxt = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		res_push = 1'b0;
		learn    = 1'b0;
		res      = '0;
		case (st_q)
			BK_IDLE:
				cmd_pop = !cmd_empty && !res_full;
			BK_READ:
				rd_en = 1'b1;
			BK_CMP: ;
			BK_DONE: begin
				res_push = 1'b1;
				if (cmd_q.drop) begin
					res.status = STS_BAD_LEN;
				end else if (cmd_q.is_query) begin
					if (cmd_q.own_query) begin
						res.action    = ACT_ANSWERED;
						res.found_mac = own_mac;
					end else if (hit_q) begin
						res.action    = ACT_ANSWERED;
						res.found_mac = rd_mac_q;
					end else begin
						res.action       = ACT_BCAST;
						res.pkt_dest_mac = MAC_BCAST;
						res.pkt_dest_ip  = cmd_q.key_ip;
					end
				end else begin
					learn       = miss_new && !tbl_full;
					res.learned = learn;
					if (!cmd_q.tgt_us) begin
						res.status = STS_NOT_US;
					end else if (cmd_q.oper_req) begin
						res.action       = ACT_REPLY;
						res.pkt_dest_mac = cmd_q.mac;
						res.pkt_dest_ip  = cmd_q.key_ip;
					end
					// a new sender that found no room overrides not-for-us
					if (miss_new && tbl_full)
						res.status = STS_FULL;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			count_q <= '0;
			addr_q  <= '0;
			hit_q   <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cmd_pop) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
			end
			if (st_q == BK_CMP) begin
				if (match)
					hit_q <= 1'b1;
				else if (!last)
					addr_q <= addr_q + 1'b1;
			end
			if (learn)
				count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd;
	end

	// entries fill from index 0 upward, so the fill count doubles as the valid bits
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ip_q  <= mem_ip[addr_q];
			rd_mac_q <= mem_mac[addr_q];
		end
		if (learn) begin
			mem_ip[count_q[IDX_W-1:0]]  <= cmd_q.key_ip;
			mem_mac[count_q[IDX_W-1:0]] <= cmd_q.mac;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_learn_count: assert property (@(posedge clk) disable iff (!arst_n)
		learn |=> count_q == $past(count_q) + 1'b1)
		else $error("learned entry not counted");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_CMP |-> $past(st_q) == BK_READ)
		else $error("compare without table read");

	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> CNT_W'(addr_q) < count_q)
		else $error("table read past fill count");

endmodule
`default_nettype wire

FILE: hdl/arp_responder_cache.sv
// ARP responder with IPv4-to-MAC address cache.
// Requests come in on a queue-style port (push/full) carrying item_t; each request
// yields exactly one result_t on a queue-style port (empty/pop), in request order.
// operation 0 is a decoded ARP packet: lengths are checked, a new sender is learned
// into the lowest free table entry, and a request aimed at own_ip orders a reply.
// operation 1 is an address query: own_ip answers own_mac, a cached IP answers its
// MAC, anything else orders a broadcast request.
// The table search reads one entry at a time, through a READ and then a CMP state,
// from a single-port table memory and stops at the first hit or at the fill count.
// Dropped packets, own-IP queries and zero or own senders skip the search. One
// request is in the back end at a time: it takes no new request until the last
// result is pushed; a two-entry command queue and a two-entry result queue
// decouple the sides, so input is taken while results wait, and a stalled pop
// backs up through both queues to full.
// Reset clears the table (fill count to zero), own_mac and own_ip, and the queues.
// own_mac is at byte address 0, own_ip at 8; write them only while the block is idle.
// Depends on arpc_pkg, arpc_fifo, arpc_front, arpc_back.
`default_nettype none
module arp_responder_cache
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire item_t             item,
	output logic                   empty,
	input  wire logic              pop,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic        wr_en;

	logic    f_cmd_push, cq_full, cq_empty, cq_pop;
	cmd_t    f_cmd, cq_cmd;
	logic    rq_full, b_res_push;
	result_t b_res;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == REG_OWN_IP) ? {32'd0, own_ip_q} : {16'd0, own_mac_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (wr_en) begin
			if (paddr[3] == REG_OWN_IP)
				own_ip_q <= pwdata[31:0];
			else
				own_mac_q <= pwdata[47:0];
		end
	end

	arpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.own_ip   (own_ip_q),
		.cmd_push (f_cmd_push),
		.cmd      (f_cmd),
		.cmd_full (cq_full)
	);

	arpc_fifo #(.T(cmd_t), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_cmd_push),
		.din    (f_cmd),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (cq_cmd),
		.empty  (cq_empty)
	);

	arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cq_empty),
		.cmd       (cq_cmd),
		.cmd_pop   (cq_pop),
		.own_mac   (own_mac_q),
		.res_full  (rq_full),
		.res_push  (b_res_push),
		.res       (b_res)
	);

	arpc_fifo #(.T(result_t), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_res_push),
		.din    (b_res),
		.full   (rq_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for arp_responder_cache: drives packets and queries, writes the APB registers
// and keeps a mirror of the address cache in a small class that checks every result.
// Depends on arpc_pkg and the arp_responder_cache RTL.
module testbench;
	import arpc_pkg::*;

	localparam int          DRAIN_CYCLES = 8 + 2 * TABLE_ENTRIES_DEF;
	localparam int          STALL_LIMIT  = 20000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          POOL_SIZE    = 24;
	localparam int          PHASES       = 5;
	localparam int          ITEM_W       = $bits(item_t);
	localparam logic [15:0] ARP_REPLY    = 16'h0002;

	class arp_cache_mirror;
		logic [47:0] mac_reg;
		logic [31:0] ip_reg;
		bit          slot_used [TABLE_ENTRIES_DEF];
		logic [31:0] slot_ip   [TABLE_ENTRIES_DEF];
		logic [47:0] slot_mac  [TABLE_ENTRIES_DEF];
		result_t     answers_due [$];
		int          errors;

		function new();
			mac_reg = '0;
			ip_reg  = '0;
			errors  = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function void set_reg(logic sel, logic [63:0] value);
			if (sel == REG_OWN_IP) ip_reg = value[31:0];
			else mac_reg = value[47:0];
		endfunction

		function int find_ip(logic [31:0] ip);
			foreach (slot_used[i])
				if (slot_used[i] && slot_ip[i] == ip) return i;
			return -1;
		endfunction

		function void take_request(item_t x);
			result_t r;
			bit      no_room;
			int      slot;
			r = '0;
			no_room = 1'b0;
			if (x.operation == OP_PACKET) begin
				if (x.hw_len != HW_LEN_ETH || x.proto_len != PROTO_LEN_IP) begin
					r.status = STS_BAD_LEN;
				end else begin
					if (x.sender_ip != '0 && x.sender_ip != ip_reg && find_ip(x.sender_ip) < 0) begin
						// lowest free slot; entries are never replaced
						slot = -1;
						foreach (slot_used[i])
							if (!slot_used[i] && slot < 0) slot = i;
						if (slot >= 0) begin
							slot_used[slot] = 1'b1;
							slot_ip[slot]   = x.sender_ip;
							slot_mac[slot]  = x.sender_mac;
							r.learned       = 1'b1;
						end else begin
							no_room = 1'b1;
						end
					end
					if (x.target_ip != ip_reg) begin
						r.status = STS_NOT_US;
					end else if (x.arp_oper == ARP_REQUEST) begin
						r.action       = ACT_REPLY;
						r.pkt_dest_mac = x.sender_mac;
						r.pkt_dest_ip  = x.sender_ip;
					end
					if (no_room) r.status = STS_FULL;
				end
			end else if (x.query_ip == ip_reg) begin
				r.action    = ACT_ANSWERED;
				r.found_mac = mac_reg;
			end else begin
				slot = find_ip(x.query_ip);
				if (slot >= 0) begin
					r.action    = ACT_ANSWERED;
					r.found_mac = slot_mac[slot];
				end else begin
					r.action       = ACT_BCAST;
					r.pkt_dest_mac = MAC_BCAST;
					r.pkt_dest_ip  = x.query_ip;
				end
			end
			answers_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %h, actual %h", name, want, got);
				errors++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (answers_due.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			compare_field("action", 64'(want.action), 64'(got.action));
			compare_field("status", 64'(want.status), 64'(got.status));
			compare_field("learned", 64'(want.learned), 64'(got.learned));
			compare_field("pkt_dest_mac", 64'(want.pkt_dest_mac), 64'(got.pkt_dest_mac));
			compare_field("pkt_dest_ip", 64'(want.pkt_dest_ip), 64'(got.pkt_dest_ip));
			compare_field("found_mac", 64'(want.found_mac), 64'(got.found_mac));
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	logic              full;
	item_t             item    = '0;
	logic              empty;
	logic              pop     = 1'b0;
	result_t           result;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	arp_cache_mirror mirror = new();
	logic [31:0]     pool [POOL_SIZE];
	bit              steady = 1'b0;  // no idling on either side
	int              idle_count = 0;

	arp_responder_cache dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_count <= 0;
		else if (arst_n) idle_count <= idle_count + 1;
		if (idle_count == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random pop gaps, plus one long hold to back the block up
	initial begin
		int seen;
		int hold;
		seen = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				mirror.match_result(result);
				seen++;
				if (seen == 500) hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= steady || ($urandom_range(99) >= 24);
			end
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [31:0] pool_ip();
		return pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	function automatic item_t arp_packet(logic [15:0] oper, logic [47:0] smac,
			logic [31:0] sip, logic [31:0] tip);
		item_t x;
		x.operation  = OP_PACKET;
		x.hw_len     = HW_LEN_ETH;
		x.proto_len  = PROTO_LEN_IP;
		x.arp_oper   = oper;
		x.sender_mac = smac;
		x.sender_ip  = sip;
		x.target_ip  = tip;
		x.query_ip   = $urandom;
		return x;
	endfunction

	function automatic item_t lookup(logic [31:0] ip);
		item_t x;
		x = arp_packet(16'($urandom), rand48(), $urandom, $urandom);
		x.hw_len    = 8'($urandom);
		x.proto_len = 8'($urandom);
		x.operation = OP_QUERY;
		x.query_ip  = ip;
		return x;
	endfunction

	function automatic item_t random_item();
		item_t       x;
		int          pick;
		int          r;
		logic [31:0] sip;
		logic [31:0] tip;
		logic [15:0] oper;
		pick = $urandom_range(99);
		x = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		if (pick < 10) return x;
		if (pick < 20) begin
			// broken length fields
			x.operation = OP_PACKET;
			if (pick < 15) x.proto_len = PROTO_LEN_IP;
			else x.hw_len = HW_LEN_ETH;
			return x;
		end
		r = $urandom_range(99);
		if (pick < 55) begin
			if (r < 45) return lookup(pool_ip());
			if (r < 60) return lookup(mirror.ip_reg);
			if (r < 70) return lookup('0);
			return lookup($urandom);
		end
		if (r < 60) sip = pool_ip();
		else if (r < 70) sip = mirror.ip_reg;
		else if (r < 80) sip = '0;
		else sip = $urandom;
		r = $urandom_range(99);
		if (r < 50) tip = mirror.ip_reg;
		else if (r < 80) tip = pool_ip();
		else tip = $urandom;
		r = $urandom_range(99);
		if (r < 70) oper = ARP_REQUEST;
		else if (r < 88) oper = ARP_REPLY;
		else oper = 16'($urandom);
		return arp_packet(oper, rand48(), sip, tip);
	endfunction

	task automatic send_item(input item_t x);
		while (!steady && $urandom_range(99) < 24) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= x;
		@(posedge clk);
		while (full) @(posedge clk);
		mirror.take_request(x);
	endtask

	task automatic write_reg(input logic sel, input logic [63:0] value);
		logic [63:0] keep;
		keep = (sel == REG_OWN_IP) ? 64'h0000_0000_ffff_ffff : 64'h0000_ffff_ffff_ffff;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		mirror.set_reg(sel, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		mirror.compare_field("register readback", value & keep, prdata & keep);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (mirror.answers_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [47:0] mac;
		logic [31:0] ip;
		item_t       x;
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = {8'($urandom_range(1, 255)), 16'($urandom), 8'(i + 1)};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					mac = rand48();
					ip  = 32'hc0a8_0001;
				end
				1: begin
					mac = '1;
					ip  = '1;
				end
				2: begin
					mac = '0;
					ip  = '0;
				end
				3: begin
					mac = rand48();
					ip  = $urandom;
				end
				default: begin
					// own IP collides with an address likely already cached
					mac = rand48();
					ip  = pool[3];
				end
			endcase
			write_reg(REG_OWN_MAC, 64'(mac));
			write_reg(REG_OWN_IP, 64'(ip));
			steady = (p == 3);

			if (p == 0) begin
				x = arp_packet(ARP_REQUEST, rand48(), pool[0], ip);
				x.hw_len = '0;
				send_item(x);
				x.hw_len    = HW_LEN_ETH;
				x.proto_len = '1;
				send_item(x);
				x.hw_len    = '1;
				x.proto_len = '0;
				send_item(x);
				send_item(lookup(ip));
				send_item(lookup(pool[0]));
				send_item(arp_packet(ARP_REQUEST, '1, pool[0], ip));
				send_item(lookup(pool[0]));
				// known sender with a new MAC: cache keeps the old one
				send_item(arp_packet(ARP_REQUEST, '0, pool[0], ip));
				send_item(lookup(pool[0]));
				send_item(arp_packet(ARP_REQUEST, rand48(), '0, ip));
				send_item(arp_packet(ARP_REQUEST, rand48(), ip, ip));
				send_item(arp_packet(ARP_REQUEST, rand48(), pool[1], pool[5]));
				send_item(arp_packet(ARP_REPLY, rand48(), pool[2], ip));
				send_item(arp_packet('1, rand48(), pool[3], ip));
				send_item(arp_packet('0, rand48(), pool[2], ip));
				send_item(arp_packet(ARP_REQUEST, '0, '1, '0));
				send_item(lookup('1));
				send_item(lookup('0));
			end

			repeat ((p == 0) ? 300 : 425) send_item(random_item());
			push <= 1'b0;
			settle();
		end

		if (mirror.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
